// File: src/nps_pkg.sv
// shared types and constants for the nearest point search block
`timescale 1ns / 1ps

package nps_pkg;

    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int RADIUS_W    = 25;
    localparam int DIST_W      = 25;
    localparam int INDEX_W     = 16;
    localparam int MAX_POINTS  = 65536;
    localparam int COUNT_W     = $clog2(MAX_POINTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ROOT_STEPS  = SQ_W / 2;
    localparam int STEP_W      = $clog2(ROOT_STEPS);
    localparam int REM_W       = DIST_W + 1;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(23726566);
    localparam logic [0:0]          REG_RADIUS   = 1'b0;

    typedef struct packed {
        logic [SQ_W-1:0] dist_sq;
        logic            last;
    } t_dist_word;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] operand;
    } t_root_req;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] root;
    } t_root_rsp;

endpackage

// File: src/nearest_point_search.sv
// top level of the nearest point search block
`timescale 1ns / 1ps

// Takes one word per cycle while full is low (query point, map point, last
// mark) and keeps the closest map point inside the search radius. Words
// flow through a two-stage distance pipeline into a four-word queue; the
// scan engine consumes one word per cycle while it is scanning. A word
// marked last starts a bit-serial square root, and no further words are
// consumed until its result is emitted; meanwhile the queue fills and then
// full is raised. One result word per scan appears behind empty. The radius
// register sits at byte address 0 of the register port.
module nearest_point_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nps_pkg::ADDR_W-1:0]          paddr,
    input  logic [nps_pkg::DATA_W-1:0]          pwdata,
    output logic [nps_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic signed [nps_pkg::COORD_W-1:0]  i_query_x,
    input  logic signed [nps_pkg::COORD_W-1:0]  i_query_y,
    input  logic signed [nps_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [nps_pkg::COORD_W-1:0]  i_point_y,
    input  logic                                i_last_point,
    output logic                                empty,
    input  logic                                pop,
    output logic [nps_pkg::DIST_W-1:0]          o_near_dist,
    output logic [nps_pkg::INDEX_W-1:0]         o_near_index,
    output logic                                o_found
);

    logic [nps_pkg::RADIUS_W-1:0] r_radius;
    logic                         q_push, q_full, q_pop, q_empty;
    nps_pkg::t_dist_word          q_in_word, q_out_word;
    nps_pkg::t_root_req           root_req;
    nps_pkg::t_root_rsp           root_rsp;
    logic                         reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = paddr[2] == nps_pkg::REG_RADIUS;
    assign prdata  = reg_hit ? nps_pkg::DATA_W'(r_radius) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= nps_pkg::RADIUS_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_radius <= pwdata[nps_pkg::RADIUS_W-1:0];
        end
    end

    nps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_query_x    (i_query_x),
        .i_query_y    (i_query_y),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_word     (q_in_word)
    );

    nps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_word  (q_out_word)
    );

    nps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_rsp   (root_rsp)
    );

    nps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_radius     (r_radius),
        .i_q_empty    (q_empty),
        .i_q_word     (q_out_word),
        .o_q_pop      (q_pop),
        .o_root_req   (root_req),
        .i_root_rsp   (root_rsp),
        .empty        (empty),
        .pop          (pop),
        .o_near_dist  (o_near_dist),
        .o_near_index (o_near_index),
        .o_found      (o_found)
    );

endmodule

// File: src/nps_front.sv
// front pipeline: accepts points and forms squared distances
`timescale 1ns / 1ps

module nps_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [nps_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [nps_pkg::COORD_W-1:0] i_query_y,
    input  logic signed [nps_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [nps_pkg::COORD_W-1:0] i_point_y,
    input  logic                             i_last_point,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output nps_pkg::t_dist_word              o_q_word
);

    function automatic logic [nps_pkg::DIFF_W-1:0] abs_diff(
        input logic signed [nps_pkg::COORD_W-1:0] a,
        input logic signed [nps_pkg::COORD_W-1:0] b
    );
        logic signed [nps_pkg::DIFF_W-1:0] d;
        d = $signed({a[nps_pkg::COORD_W-1], a}) - $signed({b[nps_pkg::COORD_W-1], b});
        return d[nps_pkg::DIFF_W-1] ? nps_pkg::DIFF_W'(-d) : nps_pkg::DIFF_W'(d);
    endfunction

    logic                        move;
    logic                        r_v1, r_v2;
    logic                        r_last1, r_last2;
    logic [nps_pkg::DIFF_W-1:0]  r_dx, r_dy;
    logic [nps_pkg::SQ_W-1:0]    r_sq_x, r_sq_y;

    assign move     = !r_v2 || !i_q_full;
    assign full     = !move;
    assign o_q_push = r_v2 && !i_q_full;
    assign o_q_word = '{dist_sq: r_sq_x + r_sq_y, last: r_last2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (move) begin
            r_v1 <= push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_dx    <= abs_diff(i_query_x, i_point_x);
            r_dy    <= abs_diff(i_query_y, i_point_y);
            r_last1 <= i_last_point;
            r_sq_x  <= nps_pkg::SQ_W'(r_dx) * nps_pkg::SQ_W'(r_dx);
            r_sq_y  <= nps_pkg::SQ_W'(r_dy) * nps_pkg::SQ_W'(r_dy);
            r_last2 <= r_last1;
        end
    end

endmodule

// File: src/nps_queue.sv
// short word queue between the front pipeline and the scan engine
`timescale 1ns / 1ps

module nps_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  nps_pkg::t_dist_word i_word,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output nps_pkg::t_dist_word o_word
);

    nps_pkg::t_dist_word          r_mem [nps_pkg::QUEUE_DEPTH];
    logic [nps_pkg::QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [nps_pkg::QCNT_W-1:0]   r_count;
    logic                         do_push, do_pop;

    assign o_full  = r_count == nps_pkg::QCNT_W'(nps_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

// File: src/nps_sqrt.sv
// iterative floor square root, one result bit per cycle
`timescale 1ns / 1ps

module nps_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nps_pkg::t_root_req i_req,
    output nps_pkg::t_root_rsp o_rsp
);

    logic                        r_busy, r_done;
    logic [nps_pkg::STEP_W-1:0]  r_step;
    logic [nps_pkg::SQ_W-1:0]    r_op;
    logic [nps_pkg::REM_W-1:0]   r_rem;
    logic [nps_pkg::DIST_W-1:0]  r_root;
    logic [nps_pkg::REM_W+1:0]   rem_shift, trial, diff;
    logic                        ge;

    always_comb begin
        rem_shift = {r_rem, r_op[nps_pkg::SQ_W-1 -: 2]};
        trial     = {1'b0, r_root, 2'b01};
        ge        = rem_shift >= trial;
        diff      = rem_shift - trial;
    end

    assign o_rsp = '{done: r_done, root: r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == nps_pkg::STEP_W'(nps_pkg::ROOT_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_step <= '0;
            r_op   <= i_req.operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            r_op   <= r_op << 2;
            r_rem  <= ge ? diff[nps_pkg::REM_W-1:0] : rem_shift[nps_pkg::REM_W-1:0];
            r_root <= {r_root[nps_pkg::DIST_W-2:0], ge};
        end
    end

endmodule

// File: src/nps_back.sv
// scan engine: keeps the best point of a scan and emits the result word
`timescale 1ns / 1ps

module nps_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [nps_pkg::RADIUS_W-1:0]  i_radius,
    input  logic                          i_q_empty,
    input  nps_pkg::t_dist_word           i_q_word,
    output logic                          o_q_pop,
    output nps_pkg::t_root_req            o_root_req,
    input  nps_pkg::t_root_rsp            i_root_rsp,
    output logic                          empty,
    input  logic                          pop,
    output logic [nps_pkg::DIST_W-1:0]    o_near_dist,
    output logic [nps_pkg::INDEX_W-1:0]   o_near_index,
    output logic                          o_found
);

    typedef enum logic [2:0] {
        ST_SCAN = 3'b001,
        ST_ROOT = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                        r_state;
    logic [nps_pkg::SQ_W-1:0]      r_radius_sq, r_best;
    logic [nps_pkg::COUNT_W-1:0]   r_count;
    logic [nps_pkg::INDEX_W-1:0]   r_idx, r_res_index;
    logic [nps_pkg::DIST_W-1:0]    r_res_dist;
    logic                          r_have, r_res_found, r_out_valid;

    logic                          first, eligible, take, have, emit;
    logic [nps_pkg::SQ_W-1:0]      thr, n_best;
    logic [nps_pkg::INDEX_W-1:0]   n_idx;
    logic                          n_have;

    assign o_q_pop = (r_state == ST_SCAN) && !i_q_empty;
    assign empty   = !r_out_valid;
    assign emit    = (r_state == ST_EMIT) && (!r_out_valid || pop);

    always_comb begin
        first    = r_count == '0;
        eligible = r_count < nps_pkg::COUNT_W'(nps_pkg::MAX_POINTS);
        thr      = first ? r_radius_sq : r_best;
        have     = first ? 1'b0 : r_have;
        take     = eligible && (i_q_word.dist_sq < thr);
        n_best   = take ? i_q_word.dist_sq : thr;
        n_have   = have || take;
        n_idx    = take ? r_count[nps_pkg::INDEX_W-1:0] : (first ? '0 : r_idx);
        o_root_req.start   = o_q_pop && i_q_word.last;
        o_root_req.operand = n_have ? n_best : '0;
    end

    always_ff @(posedge i_clk) begin
        r_radius_sq <= nps_pkg::SQ_W'(i_radius) * nps_pkg::SQ_W'(i_radius);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SCAN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_SCAN: begin
                    if (o_q_pop) begin
                        if (i_q_word.last) begin
                            r_count <= '0;
                            r_state <= ST_ROOT;
                        end else if (eligible) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                ST_ROOT: begin
                    if (i_root_rsp.done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit) begin
                        r_state <= ST_SCAN;
                    end
                end
                default: begin
                    r_state <= ST_SCAN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_best <= n_best;
            r_idx  <= n_idx;
            r_have <= n_have;
        end
        if (o_root_req.start) begin
            r_res_found <= n_have;
            r_res_index <= n_have ? n_idx : '0;
        end
        if (i_root_rsp.done) begin
            r_res_dist <= i_root_rsp.root;
        end
        if (emit) begin
            o_near_dist  <= r_res_dist;
            o_near_index <= r_res_index;
            o_found      <= r_res_found;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nps_pkg::COUNT_W'(nps_pkg::MAX_POINTS))
        else $error("point count past its limit");

    a_pop_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == ST_SCAN)
        else $error("queue popped outside scan");

    a_root_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_root_rsp.done |-> r_state == ST_ROOT)
        else $error("root finished while not waiting for it");

    a_start_leaves_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root_req.start |=> r_state == ST_ROOT && r_count == '0)
        else $error("scan did not close after last point");

endmodule
